>>> sv/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg
// shared constants, codes and types of the covisibility pair counter
// ----------------------------------------------------------------------------
package cpc_pkg;

    // camera and view list geometry (camera count is a power of two so that a
    // pair index is the concatenation of the two camera indexes)
    localparam int CAMERAS   = 64;
    localparam int MAX_VIEWS = 64;

    localparam int CAM_W    = $clog2(CAMERAS);
    localparam int LIM_W    = CAM_W + 1;
    localparam int VIEW_W   = $clog2(MAX_VIEWS);
    localparam int VCNT_W   = $clog2(MAX_VIEWS + 1);
    localparam int IDX_W    = 2 * CAM_W;
    localparam int PAIRS    = CAMERAS * CAMERAS;
    localparam int CNT_W    = 16;
    localparam int CAMCNT_W = 7;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // input action codes
    localparam logic [1:0] ACT_OBSERVE = 2'd0;
    localparam logic [1:0] ACT_SWEEP   = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;

    // register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_LOWER  = 2'd0;
    localparam logic [1:0] REG_UPPER  = 2'd1;
    localparam logic [1:0] REG_CAMCNT = 2'd2;

    localparam logic [CNT_W-1:0]    LOWER_RST  = '0;
    localparam logic [CNT_W-1:0]    UPPER_RST  = CNT_MAX;
    localparam logic [CAMCNT_W-1:0] CAMCNT_RST = CAMCNT_W'(64);

    typedef struct packed {
        logic [CNT_W-1:0] lower_bound;
        logic [CNT_W-1:0] upper_bound;
        logic [LIM_W-1:0] sweep_limit;
    } cfg_t;

    typedef struct packed {
        logic [CAM_W-1:0] first_camera;
        logic [CAM_W-1:0] second_camera;
        logic [CNT_W-1:0] pair_count;
        logic             found;
        logic             overflow;
        logic             last;
    } res_t;

endpackage

>>> sv/cpc_ram.sv
// ----------------------------------------------------------------------------
// cpc_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/cpc_ctrl.sv
// ----------------------------------------------------------------------------
// cpc_ctrl
// sequencer for observe, row sweep and clear over the view list and count ram
// ----------------------------------------------------------------------------
module cpc_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                action,
    input  logic [cpc_pkg::CAM_W-1:0] camera,
    input  logic                      last_view,
    input  logic [cpc_pkg::CAM_W-1:0] row,
    input  cpc_pkg::cfg_t             cfg,
    output logic                      res_valid,
    input  logic                      res_ready,
    output cpc_pkg::res_t             res
);
    import cpc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_OBS,
        S_SWEEP,
        S_SWEEP_END,
        S_RESP
    } state_t;

    state_t              state_reg;
    logic [VCNT_W-1:0]   view_count_reg;
    logic [VCNT_W-1:0]   n_reg;
    logic [VCNT_W-1:0]   k_reg;
    logic                b_valid_reg;
    logic                c_valid_reg;
    logic                e_valid_reg;
    logic                wr_valid_reg;
    logic                pend_valid_reg;
    logic [IDX_W-1:0]    clr_addr_reg;
    logic                clr_resp_reg;
    logic [LIM_W-1:0]    j_reg;

    logic [CAM_W-1:0]    cam_reg;
    logic [CAM_W-1:0]    row_reg;
    logic                ovf_reg;
    logic [IDX_W-1:0]    c_idx_reg;
    logic [IDX_W-1:0]    wr_idx_reg;
    logic [CNT_W-1:0]    wr_data_reg;
    logic [LIM_W-1:0]    e_col_reg;
    logic [CAM_W-1:0]    pend_col_reg;
    logic [CNT_W-1:0]    pend_cnt_reg;

    logic                accept;
    logic                list_full;
    logic                vl_we;
    logic                vl_re;
    logic [CAM_W-1:0]    vl_rdata;
    logic [CAM_W-1:0]    pair_lo;
    logic [CAM_W-1:0]    pair_hi;
    logic [IDX_W-1:0]    b_idx;
    logic                pc_re;
    logic [IDX_W-1:0]    pc_raddr;
    logic [CNT_W-1:0]    pc_rdata;
    logic                pc_we;
    logic [IDX_W-1:0]    pc_waddr;
    logic [CNT_W-1:0]    pc_wdata;
    logic [CNT_W-1:0]    c_old;
    logic [CNT_W-1:0]    c_new;
    logic                e_qual;
    logic                sw_stall;
    logic                sw_more;
    logic                sw_issue;
    logic [LIM_W-1:0]    row_next_col;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign list_full = (view_count_reg >= VCNT_W'(MAX_VIEWS));

    // view list: append at accept, read back one entry per cycle
    assign vl_we = accept && (action == ACT_OBSERVE) && !list_full;
    assign vl_re = (state_reg == S_OBS) && (k_reg < n_reg);

    cpc_ram #(
        .WIDTH (CAM_W),
        .DEPTH (MAX_VIEWS)
    ) u_view_ram (
        .clk   (clk),
        .we    (vl_we),
        .waddr (view_count_reg[VIEW_W-1:0]),
        .wdata (camera),
        .re    (vl_re),
        .raddr (k_reg[VIEW_W-1:0]),
        .rdata (vl_rdata)
    );

    // ordered pair index of the listed camera and the new one
    always_comb
    begin
        if (vl_rdata < cam_reg)
        begin
            pair_lo = vl_rdata;
            pair_hi = cam_reg;
        end
        else
        begin
            pair_lo = cam_reg;
            pair_hi = vl_rdata;
        end
    end
    assign b_idx = {pair_lo, pair_hi};

    // sweep control
    assign e_qual   = e_valid_reg && (pc_rdata >= cfg.lower_bound)
                      && (pc_rdata <= cfg.upper_bound);
    assign sw_stall = e_qual && pend_valid_reg && !res_ready;
    assign sw_more  = (j_reg < cfg.sweep_limit);
    assign sw_issue = (state_reg == S_SWEEP) && !sw_stall && sw_more;
    assign row_next_col = LIM_W'({1'b0, row} + 1'b1);

    // count ram ports
    assign pc_re    = b_valid_reg || sw_issue;
    assign pc_raddr = b_valid_reg ? b_idx : {row_reg, j_reg[CAM_W-1:0]};

    // the write of the previous cycle is not yet seen by a read issued with it
    assign c_old = (wr_valid_reg && (wr_idx_reg == c_idx_reg)) ? wr_data_reg : pc_rdata;
    assign c_new = (c_old == CNT_MAX) ? c_old : CNT_W'(c_old + 1'b1);

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            pc_we    = 1'b1;
            pc_waddr = clr_addr_reg;
            pc_wdata = '0;
        end
        else
        begin
            pc_we    = c_valid_reg;
            pc_waddr = c_idx_reg;
            pc_wdata = c_new;
        end
    end

    cpc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (PAIRS)
    ) u_count_ram (
        .clk   (clk),
        .we    (pc_we),
        .waddr (pc_waddr),
        .wdata (pc_wdata),
        .re    (pc_re),
        .raddr (pc_raddr),
        .rdata (pc_rdata)
    );

    // result to the output register
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        unique case (state_reg)
            S_SWEEP:
            begin
                res_valid         = e_qual && pend_valid_reg;
                res.first_camera  = row_reg;
                res.second_camera = pend_col_reg;
                res.pair_count    = pend_cnt_reg;
                res.found         = 1'b1;
            end
            S_SWEEP_END:
            begin
                res_valid = 1'b1;
                res.last  = 1'b1;
                if (pend_valid_reg)
                begin
                    res.first_camera  = row_reg;
                    res.second_camera = pend_col_reg;
                    res.pair_count    = pend_cnt_reg;
                    res.found         = 1'b1;
                end
            end
            S_RESP:
            begin
                res_valid    = 1'b1;
                res.overflow = ovf_reg;
                res.last     = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            view_count_reg <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            e_valid_reg    <= 1'b0;
            wr_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            clr_addr_reg   <= '0;
            clr_resp_reg   <= 1'b0;
            j_reg          <= '0;
        end
        else
        begin
            b_valid_reg  <= vl_re;
            c_valid_reg  <= b_valid_reg;
            wr_valid_reg <= c_valid_reg;
            if (vl_re)
            begin
                k_reg <= VCNT_W'(k_reg + 1'b1);
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= IDX_W'(clr_addr_reg + 1'b1);
                    if (clr_addr_reg == IDX_W'(PAIRS - 1))
                    begin
                        state_reg <= clr_resp_reg ? S_RESP : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (action)
                            ACT_OBSERVE:
                            begin
                                if (list_full)
                                begin
                                    state_reg <= S_RESP;
                                    if (last_view)
                                    begin
                                        view_count_reg <= '0;
                                    end
                                end
                                else
                                begin
                                    n_reg <= view_count_reg;
                                    k_reg <= '0;
                                    view_count_reg <= last_view ? '0
                                        : VCNT_W'(view_count_reg + 1'b1);
                                    state_reg <= (view_count_reg == '0) ? S_RESP : S_OBS;
                                end
                            end
                            ACT_SWEEP:
                            begin
                                j_reg          <= row_next_col;
                                pend_valid_reg <= 1'b0;
                                e_valid_reg    <= 1'b0;
                                state_reg      <= S_SWEEP;
                            end
                            ACT_CLEAR:
                            begin
                                clr_addr_reg <= '0;
                                clr_resp_reg <= 1'b1;
                                state_reg    <= S_CLEAR;
                            end
                            default:
                            begin
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end
                S_OBS:
                begin
                    if (!vl_re && !b_valid_reg && !c_valid_reg)
                    begin
                        state_reg <= S_RESP;
                    end
                end
                S_SWEEP:
                begin
                    if (!sw_stall)
                    begin
                        e_valid_reg <= sw_issue;
                        if (sw_issue)
                        begin
                            j_reg <= LIM_W'(j_reg + 1'b1);
                        end
                        if (e_qual)
                        begin
                            pend_valid_reg <= 1'b1;
                        end
                        if (!sw_more)
                        begin
                            state_reg <= S_SWEEP_END;
                        end
                    end
                end
                S_SWEEP_END:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RESP:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        c_idx_reg   <= b_idx;
        wr_idx_reg  <= c_idx_reg;
        wr_data_reg <= c_new;
        if (accept)
        begin
            cam_reg <= camera;
            row_reg <= row;
            ovf_reg <= (action == ACT_OBSERVE) && list_full;
        end
        if ((state_reg == S_SWEEP) && !sw_stall)
        begin
            e_col_reg <= j_reg;
            if (e_qual)
            begin
                pend_col_reg <= e_col_reg[CAM_W-1:0];
                pend_cnt_reg <= pc_rdata;
            end
        end
    end

    a_mid_result_found: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.last) |-> res.found)
        else $error("non-final result without a pair");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(b_valid_reg || c_valid_reg || e_valid_reg))
        else $error("accepting while the pipeline holds work");

    a_view_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        view_count_reg <= VCNT_W'(MAX_VIEWS))
        else $error("view count beyond list depth");

    a_sweep_above_diag: assert property (@(posedge clk) disable iff (!rst_n)
        e_valid_reg |-> (e_col_reg > {1'b0, row_reg}))
        else $error("sweep reads a column at or below the row");

    a_update_in_obs: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> (state_reg == S_OBS))
        else $error("count update outside an observe");

endmodule

>>> sv/covisibility_pair_counter_top.sv
// ----------------------------------------------------------------------------
// covisibility_pair_counter_top
// camera co-visibility matrix: pair counting, row sweep and clear
// ----------------------------------------------------------------------------
// Observations arrive grouped by point. An observe transaction of camera c
// adds one (saturating at 65535) to the count of the pair (min, max) formed
// with every camera already listed for the current point, then appends c; a
// full list drops the observation and flags overflow. One count is updated
// per cycle through a read-modify-write pipeline on the 4096-entry count
// memory; an observe with an empty list answers without touching the memory.
// A sweep of row r reads one count per cycle while the output does not stall,
// for columns r+1 up to one below the camera limit, and reports those within
// [lower_bound, upper_bound]; the last result carries last, and an empty sweep
// gives one result with only last set. A clear walks the count memory one
// entry per cycle, then answers; the same clearing pass, with no answer, runs
// after reset, during which no transaction is accepted (register writes still
// are). Items are taken one at a time; a finished result waits in the output
// register while the next item is taken.
// ----------------------------------------------------------------------------
module covisibility_pair_counter_top (
    input  logic                           clk,
    input  logic                           rst_n,

    // apb register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cpc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cpc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cpc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,

    // input channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     action,
    input  logic [cpc_pkg::CAM_W-1:0]      camera,
    input  logic                           last_view,
    input  logic [cpc_pkg::CAM_W-1:0]      row,

    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cpc_pkg::CAM_W-1:0]      first_camera,
    output logic [cpc_pkg::CAM_W-1:0]      second_camera,
    output logic [cpc_pkg::CNT_W-1:0]      pair_count,
    output logic                           found,
    output logic                           overflow,
    output logic                           last
);
    import cpc_pkg::*;

    logic [CNT_W-1:0]    lower_bound_reg;
    logic [CNT_W-1:0]    upper_bound_reg;
    logic [CAMCNT_W-1:0] camera_count_reg;
    logic                out_valid_reg;
    res_t                out_res_reg;

    logic                reg_write;
    logic [1:0]          reg_sel;
    cfg_t                cfg;
    logic                res_valid;
    logic                res_ready;
    res_t                res;

    // register file: write in the access phase, address by word
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;
    assign reg_sel   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_bound_reg  <= LOWER_RST;
            upper_bound_reg  <= UPPER_RST;
            camera_count_reg <= CAMCNT_RST;
        end
        else if (reg_write)
        begin
            unique case (reg_sel)
                REG_LOWER:  lower_bound_reg  <= pwdata[CNT_W-1:0];
                REG_UPPER:  upper_bound_reg  <= pwdata[CNT_W-1:0];
                REG_CAMCNT: camera_count_reg <= pwdata[CAMCNT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_LOWER:  prdata = APB_DATA_W'(lower_bound_reg);
            REG_UPPER:  prdata = APB_DATA_W'(upper_bound_reg);
            REG_CAMCNT: prdata = APB_DATA_W'(camera_count_reg);
            default:    prdata = '0;
        endcase
    end

    // the sweep never goes past the physical camera range
    assign cfg.lower_bound = lower_bound_reg;
    assign cfg.upper_bound = upper_bound_reg;
    assign cfg.sweep_limit = (camera_count_reg < CAMCNT_W'(CAMERAS))
                             ? LIM_W'(camera_count_reg) : LIM_W'(CAMERAS);

    cpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .camera    (camera),
        .last_view (last_view),
        .row       (row),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register, refilled in the cycle it is emptied
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign first_camera  = out_res_reg.first_camera;
    assign second_camera = out_res_reg.second_camera;
    assign pair_count    = out_res_reg.pair_count;
    assign found         = out_res_reg.found;
    assign overflow      = out_res_reg.overflow;
    assign last          = out_res_reg.last;

endmodule
